// ===== rtl/store_history_watch_table_defines.svh =====
// Assertion macros used by the store history watch table RTL.
`ifndef STORE_HISTORY_WATCH_TABLE_DEFINES_SVH
`define STORE_HISTORY_WATCH_TABLE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SHWT_CHECK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SHWT_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/shwt_pkg.sv =====
// Types, constants and codes shared by the store history watch table.
`default_nettype none
package shwt_pkg;

  localparam int REGIONS   = 4;
  localparam int GRANULES  = 64;
  localparam int HISTORY   = 4;
  localparam int MAX_STORE = 512;
  localparam int GRAIN_MAX = 256;

  localparam int REG_W   = $clog2(REGIONS);
  localparam int GI_W    = $clog2(GRANULES);
  localparam int GCNT_W  = $clog2(GRANULES + 1);
  localparam int PTR_W   = $clog2(HISTORY);
  localparam int DEPTH_W = $clog2(HISTORY + 1);
  localparam int ROW_AW  = REG_W + GI_W;
  localparam int ROWS    = REGIONS * GRANULES;
  localparam int DIV_W   = 16;
  localparam int DVS_W   = 9;
  localparam int HW      = PTR_W + 2;

  typedef enum logic [1:0] {
    MODE_STORE   = 2'd0,
    MODE_TRACK   = 2'd1,
    MODE_UNTRACK = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD      = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    DIV_LO  = 2'd0,
    DIV_HI  = 2'd1,
    DIV_CNT = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
    logic [14:0] size;
    logic [8:0]  granularity;
    logic [2:0]  history_depth;
    logic [31:0] context_tag;
    logic [5:0]  granule_index;
    logic [1:0]  history_back;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [31:0] stamp;
    logic [31:0] context_tag_out;
    logic        written;
    logic [31:0] birth_time;
  } resp_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] ctx;
    logic [31:0] tim;
  } rec_t;

  typedef struct packed {
    logic [PTR_W-1:0]       ptr;
    rec_t [HISTORY-1:0]     rec;
  } row_t;

  typedef struct packed {
    logic     item_load;
    logic     div_start;
    div_sel_e div_sel;
    logic     rc_clr;
    logic     rc_inc;
    logic     hit_set;
    logic     ix_load;
    logic     ei_load;
    logic     ix_inc;
    logic     ram_rd;
    logic     ram_wr_rec;
    logic     ram_wr_clr;
    logic     trk_commit;
    logic     sw_clr;
    logic     sw_inc;
    logic     untrack_commit;
    logic     finish;
    status_e  resp_status;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  store_bad;
    logic  region_hit;
    logic  region_last;
    logic  div_done;
    logic  div_busy;
    logic  gran_more;
    logic  track_bad;
    logic  count_bad;
    logic  table_full;
    logic  unt_found;
    logic  qry_found;
    logic  qry_bad;
    logic  sweep_last;
    logic  out_room;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/shwt_if.sv =====
// Valid/ready channel interfaces for input words and result words.
`default_nettype none
interface shwt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] address;
  logic [14:0] size;
  logic [8:0]  granularity;
  logic [2:0]  history_depth;
  logic [31:0] context_tag;
  logic [5:0]  granule_index;
  logic [1:0]  history_back;

  modport source (
    output valid, mode, address, size, granularity, history_depth, context_tag,
           granule_index, history_back,
    input  ready
  );
  modport sink (
    input  valid, mode, address, size, granularity, history_depth, context_tag,
           granule_index, history_back,
    output ready
  );
endinterface

interface shwt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        hit;
  logic [31:0] stamp;
  logic [31:0] context_tag_out;
  logic        written;
  logic [31:0] birth_time;

  modport source (
    output valid, status, hit, stamp, context_tag_out, written, birth_time,
    input  ready
  );
  modport sink (
    input  valid, status, hit, stamp, context_tag_out, written, birth_time,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/shwt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module shwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/shwt_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module shwt_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [shwt_pkg::DIV_W-1:0] dividend,
  input  wire logic [shwt_pkg::DVS_W-1:0] divisor,
  output logic                            busy,
  output logic                            done,
  output logic      [shwt_pkg::DIV_W-1:0] quot
);

  localparam int CNT_W = $clog2(shwt_pkg::DIV_W + 1);

  logic [shwt_pkg::DIV_W-1:0] q_r, q_nxt;
  logic [shwt_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [shwt_pkg::DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [shwt_pkg::DVS_W:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[shwt_pkg::DIV_W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = shwt_pkg::DVS_W'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[shwt_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[shwt_pkg::DVS_W-1:0];
        q_nxt   = {q_r[shwt_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(shwt_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

// ===== rtl/shwt_ctrl.sv =====
// Sequencing state machine of the store history watch table.
`default_nettype none
`include "store_history_watch_table_defines.svh"
module shwt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire shwt_pkg::sts_t sts,
  output shwt_pkg::cmd_t      cmd
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_DECODE  = 10'b0000000010,
    S_REGION  = 10'b0000000100,
    S_DIV_LO  = 10'b0000001000,
    S_DIV_HI  = 10'b0000010000,
    S_GRAN    = 10'b0000100000,
    S_GRAN_WR = 10'b0001000000,
    S_TRK_DIV = 10'b0010000000,
    S_SWEEP   = 10'b0100000000,
    S_FIN     = 10'b1000000000
  } state_t;

  state_t            state_r, state_nxt;
  shwt_pkg::status_e st_r, st_nxt;

  always_comb begin
    state_nxt       = state_r;
    st_nxt          = st_r;
    cmd             = '0;
    cmd.div_sel     = shwt_pkg::DIV_LO;
    cmd.resp_status = st_r;
    in_ready        = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FIN;
        case (sts.mode)
          shwt_pkg::MODE_STORE: begin
            if (sts.store_bad) begin
              st_nxt = shwt_pkg::ST_BAD;
            end else begin
              cmd.rc_clr = 1'b1;
              state_nxt  = S_REGION;
            end
          end
          shwt_pkg::MODE_TRACK: begin
            if (sts.track_bad) begin
              st_nxt = shwt_pkg::ST_BAD;
            end else begin
              cmd.div_start = 1'b1;
              cmd.div_sel   = shwt_pkg::DIV_CNT;
              state_nxt     = S_TRK_DIV;
            end
          end
          shwt_pkg::MODE_UNTRACK: begin
            if (sts.unt_found) begin
              cmd.untrack_commit = 1'b1;
              st_nxt             = shwt_pkg::ST_OK;
            end else begin
              st_nxt = shwt_pkg::ST_NOTFOUND;
            end
          end
          default: begin
            if (!sts.qry_found) begin
              st_nxt = shwt_pkg::ST_NOTFOUND;
            end else if (sts.qry_bad) begin
              st_nxt = shwt_pkg::ST_BAD;
            end else begin
              cmd.ram_rd = 1'b1;
              st_nxt     = shwt_pkg::ST_OK;
            end
          end
        endcase
      end
      S_REGION: begin
        if (sts.region_hit) begin
          cmd.hit_set   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = shwt_pkg::DIV_LO;
          state_nxt     = S_DIV_LO;
        end else if (sts.region_last) begin
          st_nxt    = shwt_pkg::ST_OK;
          state_nxt = S_FIN;
        end else begin
          cmd.rc_inc = 1'b1;
        end
      end
      S_DIV_LO: begin
        if (sts.div_done) begin
          cmd.ix_load   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = shwt_pkg::DIV_HI;
          state_nxt     = S_DIV_HI;
        end
      end
      S_DIV_HI: begin
        cmd.div_sel = shwt_pkg::DIV_HI;
        if (sts.div_done) begin
          cmd.ei_load = 1'b1;
          state_nxt   = S_GRAN;
        end
      end
      S_GRAN: begin
        if (sts.gran_more) begin
          cmd.ram_rd = 1'b1;
          state_nxt  = S_GRAN_WR;
        end else if (sts.region_last) begin
          st_nxt    = shwt_pkg::ST_OK;
          state_nxt = S_FIN;
        end else begin
          cmd.rc_inc = 1'b1;
          state_nxt  = S_REGION;
        end
      end
      S_GRAN_WR: begin
        cmd.ram_wr_rec = 1'b1;
        cmd.ix_inc     = 1'b1;
        state_nxt      = S_GRAN;
      end
      S_TRK_DIV: begin
        cmd.div_sel = shwt_pkg::DIV_CNT;
        if (sts.div_done) begin
          if (sts.count_bad) begin
            st_nxt    = shwt_pkg::ST_BAD;
            state_nxt = S_FIN;
          end else if (sts.table_full) begin
            st_nxt    = shwt_pkg::ST_FULL;
            state_nxt = S_FIN;
          end else begin
            cmd.trk_commit = 1'b1;
            cmd.sw_clr     = 1'b1;
            state_nxt      = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        cmd.ram_wr_clr = 1'b1;
        cmd.sw_inc     = 1'b1;
        if (sts.sweep_last) begin
          st_nxt    = shwt_pkg::ST_OK;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_room) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= shwt_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  `SHWT_CHECK_NOW(a_div_start_idle, cmd.div_start, !sts.div_busy)
  `SHWT_CHECK_NEXT(a_read_then_write, cmd.ram_rd && state_r == S_GRAN, state_r == S_GRAN_WR)
  `SHWT_CHECK_NEXT(a_finish_to_idle, cmd.finish, state_r == S_IDLE && in_ready)

endmodule
`default_nettype wire

// ===== rtl/shwt_dp.sv =====
// Datapath: region table, logical time, granule ring memory, divider and result register.
`default_nettype none
module shwt_dp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire shwt_pkg::item_t in_item,
  input  wire shwt_pkg::cmd_t  cmd,
  output shwt_pkg::sts_t       sts,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output shwt_pkg::resp_t      out_resp
);

  localparam int REG_W   = shwt_pkg::REG_W;
  localparam int GI_W    = shwt_pkg::GI_W;
  localparam int GCNT_W  = shwt_pkg::GCNT_W;
  localparam int PTR_W   = shwt_pkg::PTR_W;
  localparam int DEPTH_W = shwt_pkg::DEPTH_W;
  localparam int DIV_W   = shwt_pkg::DIV_W;
  localparam int DVS_W   = shwt_pkg::DVS_W;
  localparam int HW      = shwt_pkg::HW;
  localparam int NREG    = shwt_pkg::REGIONS;

  shwt_pkg::item_t    item_r;
  shwt_pkg::resp_t    resp_r, resp_nxt;
  logic               out_valid_r;
  logic [31:0]        time_r;
  logic [REG_W-1:0]   rc_r;
  logic [GCNT_W-1:0]  ix_r;
  logic [GCNT_W-1:0]  ei_r;
  logic [GI_W-1:0]    sw_r;
  logic [REG_W-1:0]   slot_r;
  logic               hit_r;

  logic [NREG-1:0]    rv_r;
  logic [31:0]        rs_r   [NREG];
  logic [32:0]        re_r   [NREG];
  logic [DVS_W-1:0]   rgr_r  [NREG];
  logic [GCNT_W-1:0]  rgn_r  [NREG];
  logic [DEPTH_W-1:0] rdep_r [NREG];
  logic [31:0]        rb_r   [NREG];

  shwt_pkg::mode_e    mode;
  logic [32:0]        addr33, end33, st33, cs33, ce33, lo_off, hi_off;
  logic [REG_W-1:0]   sel, qr, fs;
  logic               qfound;
  logic [NREG-1:0]    unt_match;
  logic [DEPTH_W-1:0] cur_dep;
  logic [DIV_W-1:0]   div_dividend, div_q;
  logic [DVS_W-1:0]   div_divisor;
  logic               div_busy, div_done;
  logic [DIV_W:0]     ei_full;
  logic [GCNT_W-1:0]  ei_val;

  logic               ram_we, ram_re;
  logic [shwt_pkg::ROW_AW-1:0] ram_waddr, ram_raddr;
  shwt_pkg::row_t     row_q, row_upd, ram_wdata;
  logic [PTR_W-1:0]   p_cur;
  logic [DEPTH_W-1:0] p_inc;
  logic [HW-1:0]      t_h;
  logic [PTR_W-1:0]   h_sel;
  logic               time_inc;

  assign mode   = shwt_pkg::mode_e'(item_r.mode);
  assign addr33 = {1'b0, item_r.address};
  assign end33  = addr33 + 33'(item_r.size);

  always_comb begin
    qr     = '0;
    qfound = 1'b0;
    fs     = '0;
    for (int i = NREG - 1; i >= 0; i--) begin
      if (rv_r[i] && rs_r[i] == item_r.address) begin
        qr     = REG_W'(i);
        qfound = 1'b1;
      end
      if (!rv_r[i]) begin
        fs = REG_W'(i);
      end
    end
    for (int i = 0; i < NREG; i++) begin
      unt_match[i] = rv_r[i] && rs_r[i] == item_r.address && re_r[i] == end33;
    end
  end

  assign sel     = (mode == shwt_pkg::MODE_QUERY) ? qr : rc_r;
  assign cur_dep = rdep_r[sel];
  assign st33    = {1'b0, rs_r[sel]};
  assign cs33    = (addr33 < st33) ? st33 : addr33;
  assign ce33    = (end33 > re_r[sel]) ? re_r[sel] : end33;
  assign lo_off  = cs33 - st33;
  assign hi_off  = ce33 - st33 - 33'd1;

  always_comb begin
    case (cmd.div_sel)
      shwt_pkg::DIV_LO: begin
        div_dividend = lo_off[DIV_W-1:0];
        div_divisor  = rgr_r[sel];
      end
      shwt_pkg::DIV_HI: begin
        div_dividend = hi_off[DIV_W-1:0];
        div_divisor  = rgr_r[sel];
      end
      default: begin
        div_dividend = DIV_W'(item_r.size) + DIV_W'(item_r.granularity) - DIV_W'(1);
        div_divisor  = item_r.granularity;
      end
    endcase
  end

  shwt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q)
  );

  assign ei_full = {1'b0, div_q} + (DIV_W + 1)'(1);
  assign ei_val  = (ei_full > (DIV_W + 1)'(rgn_r[sel])) ? rgn_r[sel] : ei_full[GCNT_W-1:0];

  // Ring update for a store: write at the current pointer, then step it.
  always_comb begin
    row_upd = row_q;
    p_cur   = ({1'b0, row_q.ptr} >= cur_dep) ? '0 : row_q.ptr;
    row_upd.rec[p_cur].valid = 1'b1;
    row_upd.rec[p_cur].ctx   = item_r.context_tag;
    row_upd.rec[p_cur].tim   = time_r;
    p_inc = DEPTH_W'(p_cur) + DEPTH_W'(1);
    row_upd.ptr = (p_inc >= cur_dep) ? '0 : p_inc[PTR_W-1:0];
  end

  // The queried slot sits history_back writes behind the newest one.
  always_comb begin
    t_h = HW'(p_cur) - HW'(1) - HW'(item_r.history_back);
    if (t_h[HW-1]) begin
      t_h = t_h + HW'(cur_dep);
    end
    h_sel = t_h[PTR_W-1:0];
  end

  assign ram_we    = cmd.ram_wr_rec || cmd.ram_wr_clr;
  assign ram_re    = cmd.ram_rd;
  assign ram_waddr = cmd.ram_wr_clr ? {slot_r, sw_r} : {rc_r, ix_r[GI_W-1:0]};
  assign ram_raddr = (mode == shwt_pkg::MODE_QUERY) ? {qr, item_r.granule_index[GI_W-1:0]}
                                                    : {rc_r, ix_r[GI_W-1:0]};
  assign ram_wdata = cmd.ram_wr_clr ? '0 : row_upd;

  shwt_ram #(
    .WIDTH ($bits(shwt_pkg::row_t)),
    .DEPTH (shwt_pkg::ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (row_q)
  );

  always_comb begin
    resp_nxt        = '0;
    resp_nxt.status = cmd.resp_status;
    if (cmd.resp_status == shwt_pkg::ST_OK) begin
      case (mode)
        shwt_pkg::MODE_STORE: begin
          resp_nxt.hit   = hit_r;
          resp_nxt.stamp = time_r;
        end
        shwt_pkg::MODE_TRACK: begin
          resp_nxt.birth_time = time_r;
        end
        shwt_pkg::MODE_QUERY: begin
          resp_nxt.stamp           = row_q.rec[h_sel].tim;
          resp_nxt.context_tag_out = row_q.rec[h_sel].ctx;
          resp_nxt.written         = row_q.rec[h_sel].valid;
          resp_nxt.birth_time      = rb_r[sel];
        end
        default: begin
          resp_nxt.hit = 1'b0;
        end
      endcase
    end
    time_inc = cmd.finish && cmd.resp_status == shwt_pkg::ST_OK &&
               ((mode == shwt_pkg::MODE_STORE && hit_r) || mode == shwt_pkg::MODE_TRACK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r        <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      rc_r        <= '0;
      ix_r        <= '0;
      ei_r        <= '0;
      sw_r        <= '0;
      slot_r      <= '0;
    end else begin
      if (cmd.rc_clr) begin
        rc_r  <= '0;
        hit_r <= 1'b0;
      end else if (cmd.rc_inc) begin
        rc_r <= rc_r + REG_W'(1);
      end
      if (cmd.hit_set) begin
        hit_r <= 1'b1;
      end
      if (cmd.ix_load) begin
        ix_r <= div_q[GCNT_W-1:0];
      end else if (cmd.ix_inc) begin
        ix_r <= ix_r + GCNT_W'(1);
      end
      if (cmd.ei_load) begin
        ei_r <= ei_val;
      end
      if (cmd.sw_clr) begin
        sw_r <= '0;
      end else if (cmd.sw_inc) begin
        sw_r <= sw_r + GI_W'(1);
      end
      if (cmd.trk_commit) begin
        slot_r   <= fs;
        rv_r[fs] <= 1'b1;
      end
      if (cmd.untrack_commit) begin
        rv_r <= rv_r & ~unt_match;
      end
      if (time_inc) begin
        time_r <= time_r + 32'd1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.item_load) begin
      item_r <= in_item;
    end
    if (cmd.finish) begin
      resp_r <= resp_nxt;
    end
    if (cmd.trk_commit) begin
      rs_r[fs]   <= item_r.address;
      re_r[fs]   <= end33;
      rgr_r[fs]  <= item_r.granularity;
      rgn_r[fs]  <= div_q[GCNT_W-1:0];
      rdep_r[fs] <= item_r.history_depth;
      rb_r[fs]   <= time_r;
    end
  end

  always_comb begin
    sts             = '0;
    sts.mode        = mode;
    sts.store_bad   = item_r.size == '0 || 32'(item_r.size) > 32'(shwt_pkg::MAX_STORE);
    sts.region_hit  = rv_r[rc_r] && rgn_r[rc_r] != '0 &&
                      end33 > st33 && addr33 < re_r[rc_r];
    sts.region_last = rc_r == REG_W'(NREG - 1);
    sts.div_done    = div_done;
    sts.div_busy    = div_busy;
    sts.gran_more   = ix_r < ei_r;
    sts.track_bad   = item_r.granularity == '0 ||
                      32'(item_r.granularity) > 32'(shwt_pkg::GRAIN_MAX) ||
                      item_r.history_depth == '0 ||
                      32'(item_r.history_depth) > 32'(shwt_pkg::HISTORY);
    sts.count_bad   = 32'(div_q) > 32'(shwt_pkg::GRANULES);
    sts.table_full  = &rv_r;
    sts.unt_found   = |unt_match;
    sts.qry_found   = qfound;
    sts.qry_bad     = {1'b0, item_r.granule_index} >= 7'(rgn_r[qr]) ||
                      DEPTH_W'(item_r.history_back) >= rdep_r[qr];
    sts.sweep_last  = sw_r == GI_W'(shwt_pkg::GRANULES - 1);
    sts.out_room    = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_resp  = resp_r;

endmodule
`default_nettype wire

// ===== rtl/store_history_watch_table.sv =====
// Top level of the store history watch table.
//
// Input words arrive on in_ch (valid/ready); each word gives exactly one result
// word on out_ch. A word is taken only while the sequencer is free; one word is
// processed at a time, and a finished result waits in the output register while
// the next word is already accepted and worked on.
// Steps from acceptance to the result being shown:
//   untrack, query and words rejected at decode: decode, then the result.
//   track: the granule count division, then the sweep that clears the region's
//   64 rows of the ring memory, one row per cycle; a track refused for its
//   granule count or for a full table ends after the division.
//   store: each region is checked in turn; a hit region takes the two granule
//   index divisions, then a read then a write back of the ring row of each
//   covered granule.
// A new word can be taken in the same cycle as the last result is first shown.
// The divider and the ring memory port set the pace of track and store words.
// Reset clears the region valid bits, the logical time and the result valid flag;
// the ring memory needs no clearing because tracking a region clears its rows.
// While the receiver stalls, the result is held and a finished next word waits
// in the sequencer until the output register frees.
`default_nettype none
module store_history_watch_table (
  input wire logic  clk,
  input wire logic  rst_n,
  shwt_in_if.sink   in_ch,
  shwt_out_if.source out_ch
);

  shwt_pkg::item_t in_item;
  shwt_pkg::resp_t out_resp;
  shwt_pkg::cmd_t  cmd;
  shwt_pkg::sts_t  sts;
  logic            in_ready;
  logic            out_valid;

  assign in_item.mode          = in_ch.mode;
  assign in_item.address       = in_ch.address;
  assign in_item.size          = in_ch.size;
  assign in_item.granularity   = in_ch.granularity;
  assign in_item.history_depth = in_ch.history_depth;
  assign in_item.context_tag   = in_ch.context_tag;
  assign in_item.granule_index = in_ch.granule_index;
  assign in_item.history_back  = in_ch.history_back;
  assign in_ch.ready           = in_ready;

  shwt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  shwt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_resp  (out_resp)
  );

  assign out_ch.valid           = out_valid;
  assign out_ch.status          = out_resp.status;
  assign out_ch.hit             = out_resp.hit;
  assign out_ch.stamp           = out_resp.stamp;
  assign out_ch.context_tag_out = out_resp.context_tag_out;
  assign out_ch.written         = out_resp.written;
  assign out_ch.birth_time      = out_resp.birth_time;

endmodule
`default_nettype wire

// ===== dv/tb_store_history_watch_table.sv =====
// Self-checking testbench for the store history watch table, with a built-in predictor.
`default_nettype none
module tb_store_history_watch_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  shwt_in_if  in_ch ();
  shwt_out_if out_ch ();

  store_history_watch_table u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted region table and ring memory.
  bit              tbl_valid [shwt_pkg::REGIONS];
  longint unsigned tbl_start [shwt_pkg::REGIONS];
  longint unsigned tbl_end   [shwt_pkg::REGIONS];
  int              tbl_grain [shwt_pkg::REGIONS];
  int              tbl_count [shwt_pkg::REGIONS];
  int              tbl_depth [shwt_pkg::REGIONS];
  logic [31:0]     tbl_birth [shwt_pkg::REGIONS];
  int              ring_ptr  [shwt_pkg::REGIONS][shwt_pkg::GRANULES];
  shwt_pkg::rec_t  ring_rec  [shwt_pkg::REGIONS][shwt_pkg::GRANULES][shwt_pkg::HISTORY];
  logic [31:0]     logical_now;

  shwt_pkg::resp_t pending_results[$];
  int    error_count = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  bit    hold_request = 1'b0;
  int    hold_left = 0;
  int    quiet_cycles = 0;

  function automatic shwt_pkg::resp_t watch_table_result(shwt_pkg::item_t w);
    shwt_pkg::resp_t res;
    longint unsigned s, e, cs, ce;
    int              si, ei, ix, d, p, cnt, h;
    int              r;
    bit              hit_any;
    bit              found;
    res = '0;
    case (shwt_pkg::mode_e'(w.mode))
      shwt_pkg::MODE_STORE: begin
        if (w.size == 0 || w.size > shwt_pkg::MAX_STORE) begin
          res.status = shwt_pkg::ST_BAD;
        end else begin
          hit_any = 1'b0;
          s = w.address;
          e = longint'(w.address) + w.size;
          for (r = 0; r < shwt_pkg::REGIONS; r++) begin
            if (!tbl_valid[r] || tbl_count[r] == 0) continue;
            if (!(e > tbl_start[r] && s < tbl_end[r])) continue;
            cs = (s < tbl_start[r]) ? tbl_start[r] : s;
            ce = (e > tbl_end[r]) ? tbl_end[r] : e;
            si = int'((cs - tbl_start[r]) / tbl_grain[r]);
            ei = int'((ce - tbl_start[r] - 1) / tbl_grain[r]) + 1;
            if (ei > tbl_count[r]) ei = tbl_count[r];
            d = tbl_depth[r];
            for (ix = si; ix < ei && ix < shwt_pkg::GRANULES; ix++) begin
              p = ring_ptr[r][ix];
              if (p >= d) p = 0;
              ring_rec[r][ix][p] = '{valid: 1'b1, ctx: w.context_tag, tim: logical_now};
              ring_ptr[r][ix] = (p + 1 >= d) ? 0 : p + 1;
            end
            hit_any = 1'b1;
          end
          res.status = shwt_pkg::ST_OK;
          res.hit = hit_any;
          res.stamp = logical_now;
          if (hit_any) logical_now++;
        end
      end
      shwt_pkg::MODE_TRACK: begin
        cnt = (int'(w.size) + int'(w.granularity) - 1) / ((w.granularity == 0) ? 1 :
              int'(w.granularity));
        if (w.granularity == 0 || w.granularity > shwt_pkg::GRAIN_MAX ||
            w.history_depth == 0 || w.history_depth > shwt_pkg::HISTORY ||
            cnt > shwt_pkg::GRANULES) begin
          res.status = shwt_pkg::ST_BAD;
        end else begin
          for (r = 0; r < shwt_pkg::REGIONS; r++) if (!tbl_valid[r]) break;
          if (r >= shwt_pkg::REGIONS) begin
            res.status = shwt_pkg::ST_FULL;
          end else begin
            tbl_valid[r] = 1'b1;
            tbl_start[r] = w.address;
            tbl_end[r]   = longint'(w.address) + w.size;
            tbl_grain[r] = w.granularity;
            tbl_count[r] = cnt;
            tbl_depth[r] = w.history_depth;
            tbl_birth[r] = logical_now;
            for (ix = 0; ix < shwt_pkg::GRANULES; ix++) begin
              ring_ptr[r][ix] = 0;
              for (h = 0; h < shwt_pkg::HISTORY; h++) ring_rec[r][ix][h] = '0;
            end
            res.status = shwt_pkg::ST_OK;
            res.birth_time = logical_now;
            logical_now++;
          end
        end
      end
      shwt_pkg::MODE_UNTRACK: begin
        found = 1'b0;
        e = longint'(w.address) + w.size;
        for (r = 0; r < shwt_pkg::REGIONS; r++) begin
          if (tbl_valid[r] && tbl_start[r] == w.address && tbl_end[r] == e) begin
            tbl_valid[r] = 1'b0;
            found = 1'b1;
          end
        end
        res.status = found ? shwt_pkg::ST_OK : shwt_pkg::ST_NOTFOUND;
      end
      default: begin
        for (r = 0; r < shwt_pkg::REGIONS; r++)
          if (tbl_valid[r] && tbl_start[r] == w.address) break;
        if (r >= shwt_pkg::REGIONS) begin
          res.status = shwt_pkg::ST_NOTFOUND;
        end else begin
          d = tbl_depth[r];
          if (w.granule_index >= tbl_count[r] || w.history_back >= d) begin
            res.status = shwt_pkg::ST_BAD;
          end else begin
            p = ring_ptr[r][w.granule_index];
            if (p >= d) p = 0;
            h = (p + 2 * d - 1 - w.history_back) % d;
            res.status = shwt_pkg::ST_OK;
            res.stamp = ring_rec[r][w.granule_index][h].tim;
            res.context_tag_out = ring_rec[r][w.granule_index][h].ctx;
            res.written = ring_rec[r][w.granule_index][h].valid;
            res.birth_time = tbl_birth[r];
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic shwt_pkg::item_t make_word(shwt_pkg::mode_e m, logic [31:0] addr,
                                                int sz, int grain, int depth,
                                                logic [31:0] tag, int gi, int back);
    shwt_pkg::item_t w;
    w.mode = m;
    w.address = addr;
    w.size = sz[14:0];
    w.granularity = grain[8:0];
    w.history_depth = depth[2:0];
    w.context_tag = tag;
    w.granule_index = gi[5:0];
    w.history_back = back[1:0];
    return w;
  endfunction

  task automatic send_word(shwt_pkg::item_t w);
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= w.mode;
    in_ch.address       <= w.address;
    in_ch.size          <= w.size;
    in_ch.granularity   <= w.granularity;
    in_ch.history_depth <= w.history_depth;
    in_ch.context_tag   <= w.context_tag;
    in_ch.granule_index <= w.granule_index;
    in_ch.history_back  <= w.history_back;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(watch_table_result(w));
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic int pick_region();
    int start_at;
    int k;
    start_at = $urandom_range(shwt_pkg::REGIONS - 1);
    for (k = 0; k < shwt_pkg::REGIONS; k++)
      if (tbl_valid[(start_at + k) % shwt_pkg::REGIONS])
        return (start_at + k) % shwt_pkg::REGIONS;
    return -1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
      error_count++;
    end
  endfunction

  // Result checking, receiver stalls and the no-progress watchdog.
  always @(posedge clk) begin
    shwt_pkg::resp_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result word arrived with no expectation waiting");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, out_ch.status);
          check_field("hit", want.hit, out_ch.hit);
          check_field("stamp", want.stamp, out_ch.stamp);
          check_field("context_tag_out", want.context_tag_out, out_ch.context_tag_out);
          check_field("written", want.written, out_ch.written);
          check_field("birth_time", want.birth_time, out_ch.birth_time);
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic test_track_settings();
    send_word(make_word(shwt_pkg::MODE_TRACK, 32'h0000_1000, 256, 16, 4, 0, 0, 0));
    send_word(make_word(shwt_pkg::MODE_TRACK, 32'hFFFF_FF00, 512, 256, 1, 0, 0, 0));
    send_word(make_word(shwt_pkg::MODE_TRACK, 32'h0000_8000, 0, 1, 2, 0, 0, 0));
    send_word(make_word(shwt_pkg::MODE_TRACK, 32'h0000_2000, 64, 0, 2, 0, 0, 0));
    send_word(make_word(shwt_pkg::MODE_TRACK, 32'h0000_2000, 64, 511, 2, 0, 0, 0));
    send_word(make_word(shwt_pkg::MODE_TRACK, 32'h0000_2000, 64, 4, 0, 0, 0, 0));
    send_word(make_word(shwt_pkg::MODE_TRACK, 32'h0000_2000, 64, 4, 7, 0, 0, 0));
    send_word(make_word(shwt_pkg::MODE_TRACK, 32'h0000_2000, 16384, 1, 2, 0, 0, 0));
    send_word(make_word(shwt_pkg::MODE_TRACK, 32'h0000_0000, 64, 1, 3, 0, 0, 0));
    send_word(make_word(shwt_pkg::MODE_TRACK, 32'h0000_4000, 64, 1, 3, 0, 0, 0));
  endtask

  task automatic test_store_and_query();
    send_word(make_word(shwt_pkg::MODE_STORE, 32'h0000_1000, 0, 0, 0, 32'hDEAD_BEEF, 0, 0));
    send_word(make_word(shwt_pkg::MODE_STORE, 32'h0000_1000, 513, 0, 0, 32'h1, 0, 0));
    send_word(make_word(shwt_pkg::MODE_STORE, 32'h0000_0F00, 512, 0, 0, 32'hFFFF_FFFF, 0, 0));
    send_word(make_word(shwt_pkg::MODE_STORE, 32'h0000_0FF8, 24, 0, 0, 32'h1234_5678, 0, 0));
    send_word(make_word(shwt_pkg::MODE_STORE, 32'h0000_8000, 8, 0, 0, 32'h5, 0, 0));
    send_word(make_word(shwt_pkg::MODE_STORE, 32'hFFFF_FFFF, 512, 0, 0, 32'hA5A5_A5A5, 0, 0));
    send_word(make_word(shwt_pkg::MODE_STORE, 32'h0000_3000, 1, 0, 0, 32'h6, 0, 0));
    send_word(make_word(shwt_pkg::MODE_QUERY, 32'h0000_1000, 0, 0, 0, 0, 0, 0));
    send_word(make_word(shwt_pkg::MODE_QUERY, 32'h0000_1000, 0, 0, 0, 0, 1, 3));
    send_word(make_word(shwt_pkg::MODE_QUERY, 32'h0000_1000, 0, 0, 0, 0, 63, 0));
    send_word(make_word(shwt_pkg::MODE_QUERY, 32'hFFFF_FF00, 0, 0, 0, 0, 1, 1));
    send_word(make_word(shwt_pkg::MODE_QUERY, 32'hFFFF_FF00, 0, 0, 0, 0, 0, 0));
    send_word(make_word(shwt_pkg::MODE_QUERY, 32'h0000_7777, 0, 0, 0, 0, 0, 0));
    send_word(make_word(shwt_pkg::MODE_UNTRACK, 32'h0000_1000, 255, 0, 0, 0, 0, 0));
    send_word(make_word(shwt_pkg::MODE_UNTRACK, 32'h0000_8000, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic(int count);
    shwt_pkg::item_t w;
    int              r, pick, span;
    logic [31:0]     base;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      r = pick_region();
      w = make_word(shwt_pkg::mode_e'($urandom_range(3)), $urandom, $urandom_range(32767),
                    $urandom_range(511), $urandom_range(7), $urandom,
                    $urandom_range(63), $urandom_range(3));
      if (pick < 12 || r < 0) begin
        w.mode = shwt_pkg::MODE_TRACK;
        if ($urandom_range(9) != 0) begin
          base = (pick % 3 == 0) ? 32'hFFFF_FE00 + 32'($urandom_range(255)) :
                 (32'($urandom_range(15)) << 12) + 32'($urandom_range(63));
          w.address = base;
          w.granularity = 9'($urandom_range(1, 256));
          w.size = 15'($urandom_range(0, w.granularity * shwt_pkg::GRANULES));
          if ($urandom_range(3) == 0) w.size = 15'($urandom_range(0, 512));
          w.history_depth = 3'($urandom_range(1, shwt_pkg::HISTORY));
        end
      end else if (pick < 20) begin
        w.mode = shwt_pkg::MODE_UNTRACK;
        if ($urandom_range(4) != 0) begin
          w.address = tbl_start[r][31:0];
          w.size = 15'(tbl_end[r] - tbl_start[r]);
        end
      end else if (pick < 38) begin
        w.mode = shwt_pkg::MODE_QUERY;
        if ($urandom_range(9) != 0) begin
          w.address = tbl_start[r][31:0];
          if (tbl_count[r] > 0) w.granule_index = 6'($urandom_range(tbl_count[r] - 1));
          w.history_back = 2'($urandom_range(tbl_depth[r] - 1));
        end
      end else if (pick < 95) begin
        w.mode = shwt_pkg::MODE_STORE;
        span = int'(tbl_end[r] - tbl_start[r]);
        w.address = tbl_start[r][31:0] + 32'($urandom_range(span)) -
                    32'($urandom_range(64));
        w.size = (pick == 94) ? 15'($urandom_range(513, 32767)) :
                 15'($urandom_range(1, shwt_pkg::MAX_STORE));
      end
      send_word(w);
    end
  endtask

  task automatic test_output_backpressure();
    hold_request = 1'b1;
    test_random_traffic(30);
  endtask

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.mode          <= shwt_pkg::MODE_STORE;
    in_ch.address       <= '0;
    in_ch.size          <= '0;
    in_ch.granularity   <= '0;
    in_ch.history_depth <= '0;
    in_ch.context_tag   <= '0;
    in_ch.granule_index <= '0;
    in_ch.history_back  <= '0;
    for (int r = 0; r < shwt_pkg::REGIONS; r++) begin
      tbl_valid[r] = 1'b0;
      tbl_start[r] = 0;
      tbl_end[r]   = 0;
      tbl_grain[r] = 1;
      tbl_count[r] = 0;
      tbl_depth[r] = 1;
      tbl_birth[r] = '0;
    end
    logical_now = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_track_settings();
    test_store_and_query();
    send_idle_pct = 15;
    recv_idle_pct = 45;
    test_random_traffic(450);
    test_output_backpressure();
    send_idle_pct = 45;
    recv_idle_pct = 15;
    test_random_traffic(450);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(450);
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/shwt_pkg.sv
rtl/shwt_if.sv
rtl/shwt_ram.sv
rtl/shwt_div.sv
rtl/shwt_ctrl.sv
rtl/shwt_dp.sv
rtl/store_history_watch_table.sv
dv/tb_store_history_watch_table.sv
